// ----- src/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the LED pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

	localparam int MAX_STEPS = 16;
	localparam int POS_W     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int LEN_W     = $clog2(MAX_STEPS + 1);
	localparam int CNT_W     = POS_W + 1;
	localparam int DUR_W     = 32;
	localparam int REP_W     = 32;

	localparam logic [DUR_W-1:0] DUR_ALL_ONES = {DUR_W{1'b1}};

	localparam logic [2:0] MODE_TICK   = 3'd0;
	localparam logic [2:0] MODE_WRITE  = 3'd1;
	localparam logic [2:0] MODE_COMMIT = 3'd2;
	localparam logic [2:0] MODE_SOLID  = 3'd3;
	localparam logic [2:0] MODE_BLINK  = 3'd4;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_WRITE,
		OP_COMMIT,
		OP_SOLID,
		OP_BLINK,
		OP_REJECT
	} op_t;

	typedef struct packed {
		logic [2:0]        mode;
		logic [3:0]        step_index;
		logic              step_level;
		logic [31:0]       step_ms;
		logic [31:0]       off_duration_ms;
		logic [7:0]        step_count;
		logic signed [31:0] repeat_cycles;
	} item_t;

	typedef struct packed {
		logic led_on;
		logic status;
		logic running;
	} result_t;

	typedef struct packed {
		op_t                op;
		logic [POS_W-1:0]   idx;
		logic               lvl;
		logic [DUR_W-1:0]   dur;
		logic [DUR_W-1:0]   offd;
		logic [LEN_W-1:0]   len;
		logic signed [REP_W-1:0] reps;
	} cmd_t;

	typedef struct packed {
		logic             tick_go;
		logic             pend;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
	} lps_stat_t;

endpackage

`default_nettype wire

// ----- src/led_pattern_sequencer_core.sv -----
// An accepted item waits in the command queue; its result is then registered in the
// result queue. Throughput: one item per cycle while the command queue is not full;
// execution retires one command each cycle while the two-entry result queue has room.
// Reset: arst_n clears all control state and both queues; the LED is off and no
// pattern runs. Step stores hold no reset value and are defined once written.
// ----------------------------------------------------------------------------
// led_pattern_sequencer_core
// Top level: decode, command queue and pattern execution.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_sequencer_core
	import lps_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	cmd_t      dec_cmd;
	cmd_t      q_cmd;
	logic      cmd_empty;
	logic      cmd_pop;
	lps_stat_t stat;

	lps_front u_front (
		.item (item),
		.cmd  (dec_cmd)
	);

	lps_cmd_fifo u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (dec_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.rd_cmd (q_cmd),
		.empty  (cmd_empty)
	);

	lps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop),
		.stat      (stat)
	);

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.len == '0) || (CNT_W'(stat.pos) < CNT_W'(stat.len)))
		else $error("step position beyond pattern length");

	a_tick_takes_request: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.tick_go && stat.pend) |=> !stat.pend)
		else $error("pending request survived a tick");

	a_transfer_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !cmd_empty)
		else $error("accepted item missing from command queue");

endmodule

`default_nettype wire

// ----- src/lps_front.sv -----
// ----------------------------------------------------------------------------
// lps_front
// Decodes an incoming item into a command for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_front
	import lps_pkg::*;
(
	input  item_t item,
	output cmd_t  cmd
);

	logic count_bad;
	logic idx_ok;

	assign count_bad = (item.step_count == 8'd0) || (32'(item.step_count) > MAX_STEPS);
	assign idx_ok    = 32'(item.step_index) < MAX_STEPS;

	always_comb begin
		cmd.idx  = POS_W'(item.step_index);
		cmd.lvl  = item.step_level;
		cmd.dur  = item.step_ms;
		cmd.offd = item.off_duration_ms;
		cmd.len  = LEN_W'(item.step_count);
		cmd.reps = item.repeat_cycles;
		case (item.mode)
			MODE_TICK:   cmd.op = OP_TICK;
			MODE_WRITE:  cmd.op = idx_ok ? OP_WRITE : OP_NOP;
			MODE_COMMIT: cmd.op = count_bad ? OP_REJECT : OP_COMMIT;
			MODE_SOLID:  cmd.op = OP_SOLID;
			MODE_BLINK:  cmd.op = OP_BLINK;
			default:     cmd.op = OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/lps_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// lps_cmd_fifo
// Two-entry command queue between decode and execution.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_cmd_fifo
	import lps_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic pop,
	output cmd_t rd_cmd,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/lps_back.sv -----
// ----------------------------------------------------------------------------
// lps_back
// Executes commands on the pattern state and queues one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_back
	import lps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	output result_t   result,
	output logic      empty,
	input  logic      pop,
	output lps_stat_t stat
);

	// staging and active step stores
	logic             st_lvl_q  [MAX_STEPS];
	logic [DUR_W-1:0] st_dur_q  [MAX_STEPS];
	logic             act_lvl_q [MAX_STEPS];
	logic [DUR_W-1:0] act_dur_q [MAX_STEPS];

	logic                    pend_q;
	logic [LEN_W-1:0]        st_len_q;
	logic signed [REP_W-1:0] st_reps_q;
	logic [LEN_W-1:0]        len_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [REP_W-1:0] reps_q;
	logic [DUR_W-1:0]        el_q;
	logic                    led_q;

	result_t    res_q [2];
	logic       rwp_q;
	logic       rrp_q;
	logic [1:0] rcnt_q;

	logic do_exec;
	logic do_rpop;

	logic                    pend_n;
	logic [LEN_W-1:0]        st_len_n;
	logic signed [REP_W-1:0] st_reps_n;
	logic [LEN_W-1:0]        len_n;
	logic [POS_W-1:0]        pos_n;
	logic signed [REP_W-1:0] reps_n;
	logic [DUR_W-1:0]        el_n;
	logic                    led_n;
	logic                    status_n;
	logic                    copy_en;
	logic                    wr_en;
	logic                    pre0_en;
	logic                    pre1_en;
	logic                    pre0_lvl;
	logic [DUR_W-1:0]        pre0_dur;

	logic [LEN_W-1:0]        e_len;
	logic [POS_W-1:0]        e_pos;
	logic signed [REP_W-1:0] e_reps;
	logic [DUR_W-1:0]        e_el;
	logic [DUR_W-1:0]        e_dur;
	logic [CNT_W-1:0]        nxt_raw;
	logic                    wrap;
	logic [POS_W-1:0]        lvl_pos;
	logic                    lvl_at;
	logic signed [REP_W-1:0] reps_dec;
	logic                    expired;

	assign do_exec = !cmd_empty && (rcnt_q != 2'd2);
	assign cmd_pop = do_exec;
	assign do_rpop = pop && (rcnt_q != 2'd0);
	assign empty   = (rcnt_q == 2'd0);
	assign result  = res_q[rrp_q];

	// effective view of the tick: a pending request replaces the active pattern first
	always_comb begin
		if (pend_q) begin
			e_len  = st_len_q;
			e_pos  = '0;
			e_reps = st_reps_q;
			e_el   = '0;
			e_dur  = st_dur_q[0];
		end else begin
			e_len  = len_q;
			e_pos  = pos_q;
			e_reps = reps_q;
			e_el   = (el_q != DUR_ALL_ONES) ? el_q + DUR_W'(1) : el_q;
			e_dur  = act_dur_q[pos_q];
		end
		nxt_raw  = CNT_W'(e_pos) + CNT_W'(1);
		wrap     = nxt_raw >= CNT_W'(e_len);
		lvl_pos  = wrap ? '0 : nxt_raw[POS_W-1:0];
		if (pend_q) begin
			lvl_at = (lvl_pos == '0) ? st_lvl_q[0] : st_lvl_q[1];
		end else begin
			lvl_at = act_lvl_q[lvl_pos];
		end
		reps_dec = (!e_reps[REP_W-1] && (e_reps != '0)) ? e_reps - REP_W'(1) : e_reps;
		expired  = (e_reps != '0) && (e_len != '0) && !(e_el < e_dur);
	end

	always_comb begin
		pend_n    = pend_q;
		st_len_n  = st_len_q;
		st_reps_n = st_reps_q;
		len_n     = len_q;
		pos_n     = pos_q;
		reps_n    = reps_q;
		el_n      = el_q;
		led_n     = led_q;
		status_n  = 1'b0;
		copy_en   = 1'b0;
		wr_en     = 1'b0;
		pre0_en   = 1'b0;
		pre1_en   = 1'b0;
		pre0_lvl  = cmd.lvl;
		pre0_dur  = DUR_ALL_ONES;
		case (cmd.op)
			OP_TICK: begin
				copy_en = pend_q;
				pend_n  = 1'b0;
				len_n   = e_len;
				pos_n   = e_pos;
				reps_n  = e_reps;
				el_n    = e_el;
				led_n   = pend_q ? st_lvl_q[0] : led_q;
				if (expired) begin
					pos_n = lvl_pos;
					if (wrap) begin
						reps_n = reps_dec;
					end
					if (wrap && (reps_dec == '0)) begin
						led_n = 1'b0;
					end else begin
						el_n  = '0;
						led_n = lvl_at;
					end
				end
			end
			OP_WRITE: begin
				wr_en = 1'b1;
			end
			OP_COMMIT: begin
				st_len_n  = cmd.len;
				st_reps_n = cmd.reps;
				pend_n    = 1'b1;
			end
			OP_SOLID: begin
				pre0_en   = 1'b1;
				st_len_n  = LEN_W'(1);
				st_reps_n = -REP_W'(1);
				pend_n    = 1'b1;
			end
			OP_BLINK: begin
				pre0_en   = 1'b1;
				pre1_en   = 1'b1;
				pre0_lvl  = 1'b1;
				pre0_dur  = cmd.dur;
				st_len_n  = LEN_W'(2);
				st_reps_n = cmd.reps;
				pend_n    = 1'b1;
			end
			OP_REJECT: begin
				status_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// step stores: no reset, entries are undefined until written
	always_ff @(posedge clk) begin
		if (do_exec) begin
			for (int i = 0; i < MAX_STEPS; i++) begin
				if (wr_en && (cmd.idx == POS_W'(i))) begin
					st_lvl_q[i] <= cmd.lvl;
					st_dur_q[i] <= cmd.dur;
				end else if (pre0_en && (i == 0)) begin
					st_lvl_q[i] <= pre0_lvl;
					st_dur_q[i] <= pre0_dur;
				end else if (pre1_en && (i == 1)) begin
					st_lvl_q[i] <= 1'b0;
					st_dur_q[i] <= cmd.offd;
				end
				if (copy_en) begin
					act_lvl_q[i] <= st_lvl_q[i];
					act_dur_q[i] <= st_dur_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_exec) begin
			res_q[rwp_q] <= '{led_on: led_n, status: status_n,
				running: (reps_n != '0) && (len_n != '0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= 1'b0;
			st_len_q  <= '0;
			st_reps_q <= '0;
			len_q     <= '0;
			pos_q     <= '0;
			reps_q    <= '0;
			el_q      <= '0;
			led_q     <= 1'b0;
			rwp_q     <= 1'b0;
			rrp_q     <= 1'b0;
			rcnt_q    <= 2'd0;
		end else begin
			if (do_exec) begin
				pend_q    <= pend_n;
				st_len_q  <= st_len_n;
				st_reps_q <= st_reps_n;
				len_q     <= len_n;
				pos_q     <= pos_n;
				reps_q    <= reps_n;
				el_q      <= el_n;
				led_q     <= led_n;
				rwp_q     <= ~rwp_q;
			end
			if (do_rpop) begin
				rrp_q <= ~rrp_q;
			end
			case ({do_exec, do_rpop})
				2'b10:   rcnt_q <= rcnt_q + 2'd1;
				2'b01:   rcnt_q <= rcnt_q - 2'd1;
				default: rcnt_q <= rcnt_q;
			endcase
		end
	end

	assign stat = '{tick_go: do_exec && (cmd.op == OP_TICK), pend: pend_q,
		pos: pos_q, len: len_q};

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives LED pattern commands and millisecond ticks into the sequencer core.
// A local shadow of the sequencer predicts the LED, status and running flags
// for every accepted command. Each result popped from the core is checked
// against the oldest prediction. The run goes through several phases of
// sender and receiver idling, two long receiver stalls and drain pauses.
// ----------------------------------------------------------------------------

module testbench;
	import lps_pkg::*;

	localparam int RANDOM_ITEMS     = 700;
	localparam int PHASE_ITEMS      = 175;
	localparam int HOLD_CYCLES      = 64;
	localparam int WATCHDOG_LIMIT   = 2000;
	localparam int END_DRAIN_CYCLES = 8;

	localparam logic [2:0] MODE_SPARE_LAST = 3'd7;

	typedef struct {
		item_t       it;
		int unsigned tx_idle;
		int unsigned rx_idle;
		bit          drain_first;
		bit          rx_hold;
	} stim_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;

	led_pattern_sequencer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	stim_t       item_backlog[$];
	result_t     led_expected[$];
	int          in_flight = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_req_cnt = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned idle_cycles = 0;
	int          err_count = 0;

	// stimulus generation state
	int unsigned          gen_tx = 0;
	int unsigned          gen_rx = 0;
	bit                   gen_drain = 1'b0;
	bit                   gen_hold = 1'b0;
	int unsigned          gen_phase = 0;
	int unsigned          rand_count = 0;
	bit [MAX_STEPS-1:0]   slot_written = '0;

	// shadow of the sequencer
	logic                 stage_lvl[MAX_STEPS];
	logic [DUR_W-1:0]     stage_dur[MAX_STEPS];
	logic                 play_lvl[MAX_STEPS];
	logic [DUR_W-1:0]     play_dur[MAX_STEPS];
	logic [7:0]           stage_len = '0;
	logic signed [31:0]   stage_reps = '0;
	bit                   load_req = 1'b0;
	logic [7:0]           play_len = '0;
	int unsigned          play_pos = 0;
	logic signed [31:0]   reps_remaining = '0;
	logic [DUR_W-1:0]     ms_in_step = '0;
	logic                 led_now = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		err_count++;
	endtask

	function automatic result_t predict_led(item_t it);
		result_t r;
		bit      done;
		r = '0;
		case (it.mode)
		MODE_TICK: begin
			if (load_req) begin
				play_lvl = stage_lvl;
				play_dur = stage_dur;
				play_pos = 0;
				reps_remaining = stage_reps;
				play_len = stage_len;
				ms_in_step = '0;
				led_now = play_lvl[0];
				load_req = 1'b0;
			end else if (ms_in_step != DUR_ALL_ONES) begin
				ms_in_step = ms_in_step + 1;
			end
			if (reps_remaining != 0 && play_len != 0 && ms_in_step >= play_dur[play_pos]) begin
				// one step advance per tick at most
				done = 1'b0;
				play_pos++;
				if (play_pos >= play_len) begin
					play_pos = 0;
					if (reps_remaining > 0)
						reps_remaining = reps_remaining - 1;
					if (reps_remaining == 0) begin
						led_now = 1'b0;
						done = 1'b1;
					end
				end
				if (!done) begin
					ms_in_step = '0;
					led_now = play_lvl[play_pos];
				end
			end
		end
		MODE_WRITE: begin
			if (it.step_index < MAX_STEPS) begin
				stage_lvl[it.step_index] = it.step_level;
				stage_dur[it.step_index] = it.step_ms;
			end
		end
		MODE_COMMIT: begin
			if (it.step_count == 0 || it.step_count > MAX_STEPS) begin
				r.status = 1'b1;
			end else begin
				stage_len = it.step_count;
				stage_reps = it.repeat_cycles;
				load_req = 1'b1;
			end
		end
		MODE_SOLID: begin
			stage_lvl[0] = it.step_level;
			stage_dur[0] = DUR_ALL_ONES;
			stage_len = 8'd1;
			stage_reps = -1;
			load_req = 1'b1;
		end
		MODE_BLINK: begin
			stage_lvl[0] = 1'b1;
			stage_dur[0] = it.step_ms;
			stage_lvl[1] = 1'b0;
			stage_dur[1] = it.off_duration_ms;
			stage_len = 8'd2;
			stage_reps = it.repeat_cycles;
			load_req = 1'b1;
		end
		default: begin
		end
		endcase
		r.led_on = led_now;
		r.running = (reps_remaining != 0 && play_len != 0);
		return r;
	endfunction

	function automatic item_t mk_item(logic [2:0] mode, logic [3:0] idx, logic lvl,
			logic [31:0] dur, logic [31:0] offd, logic [7:0] cnt, logic signed [31:0] reps);
		item_t it;
		it.mode = mode;
		it.step_index = idx;
		it.step_level = lvl;
		it.step_ms = dur;
		it.off_duration_ms = offd;
		it.step_count = cnt;
		it.repeat_cycles = reps;
		return it;
	endfunction

	function automatic logic [31:0] short_dur();
		if ($urandom_range(9) == 0)
			return $urandom;
		return $urandom_range(4);
	endfunction

	function automatic logic signed [31:0] pick_repeats();
		int unsigned k;
		k = $urandom_range(19);
		if (k == 0)
			return $urandom;
		if (k == 1)
			return 32'sh8000_0000;
		if (k == 2)
			return 32'sh7fff_ffff;
		return int'($urandom_range(4)) - 1;
	endfunction

	task automatic push_stim(item_t it);
		stim_t s;
		s.it = it;
		s.tx_idle = gen_tx;
		s.rx_idle = gen_rx;
		s.drain_first = gen_drain;
		s.rx_hold = gen_hold;
		gen_drain = 1'b0;
		gen_hold = 1'b0;
		case (it.mode)
		MODE_WRITE: slot_written[it.step_index] = 1'b1;
		MODE_SOLID: slot_written[0] = 1'b1;
		MODE_BLINK: slot_written[1:0] = 2'b11;
		default: begin
		end
		endcase
		if (it.mode <= MODE_BLINK)
			rand_count++;
		item_backlog.push_back(s);
	endtask

	// A commit must never pull in a slot that was never written: fill gaps first.
	task automatic add_item(item_t it);
		int unsigned k;
		if (it.mode == MODE_COMMIT && it.step_count != 0 && it.step_count <= MAX_STEPS) begin
			for (k = 0; k < it.step_count; k++) begin
				if (!slot_written[k])
					push_stim(mk_item(MODE_WRITE, k[3:0], 1'($urandom_range(1)), short_dur(),
						$urandom, 8'($urandom), $urandom));
			end
		end
		push_stim(it);
	endtask

	task automatic add_ticks(int unsigned n);
		int unsigned k;
		for (k = 0; k < n; k++)
			add_item(mk_item(MODE_TICK, 4'($urandom), 1'($urandom), $urandom, $urandom,
				8'($urandom), $urandom));
	endtask

	// driver
	always @(posedge clk) begin
		stim_t s;
		int    acc_in;
		int    acc_out;
		if (!arst_n) begin
			push <= 1'b0;
			in_flight <= 0;
		end else begin
			acc_in = (push && !full) ? 1 : 0;
			acc_out = (pop && !empty) ? 1 : 0;
			if (acc_in != 0)
				led_expected.push_back(predict_led(item));
			in_flight <= in_flight + acc_in - acc_out;
			if (push && full) begin
				// hold the item until the core takes it
			end else if (item_backlog.size() != 0
					&& (!item_backlog[0].drain_first || in_flight + acc_in - acc_out == 0)
					&& $urandom_range(99) >= item_backlog[0].tx_idle) begin
				s = item_backlog.pop_front();
				item <= s.it;
				push <= 1'b1;
				rx_idle_pct <= s.rx_idle;
				if (s.rx_hold)
					hold_req_cnt <= hold_req_cnt + 1;
			end else begin
				push <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		bit      go;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (led_expected.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = led_expected.pop_front();
					if (result.led_on !== want.led_on)
						report_mismatch($sformatf("led_on got %0b expected %0b",
							result.led_on, want.led_on));
					if (result.status !== want.status)
						report_mismatch($sformatf("status field got %0b expected %0b",
							result.status, want.status));
					if (result.running !== want.running)
						report_mismatch($sformatf("running got %0b expected %0b",
							result.running, want.running));
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				go = 1'b0;
			end else if (hold_seen != hold_req_cnt) begin
				hold_seen <= hold_req_cnt;
				hold_left <= HOLD_CYCLES;
				go = 1'b0;
			end else begin
				go = ($urandom_range(99) >= rx_idle_pct);
			end
			pop <= go;
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned kind;
		int unsigned n;
		int unsigned k;
		for (k = 0; k < MAX_STEPS; k++) begin
			stage_lvl[k] = 1'b0;
			stage_dur[k] = '0;
			play_lvl[k] = 1'b0;
			play_dur[k] = '0;
		end

		// directed part
		add_item(mk_item(MODE_TICK, 4'd0, 1'b0, '0, '0, 8'd0, 32'sd0));
		add_item(mk_item(MODE_WRITE, 4'd0, 1'b1, 32'd0, '0, 8'd0, 32'sd0));
		add_item(mk_item(MODE_WRITE, 4'd1, 1'b0, 32'd2, '0, 8'd0, 32'sd0));
		add_item(mk_item(MODE_WRITE, 4'd2, 1'b1, 32'd1, '0, 8'd0, 32'sd0));
		add_item(mk_item(MODE_COMMIT, 4'd0, 1'b0, '0, '0, 8'd0, 32'sd1));
		add_item(mk_item(MODE_COMMIT, 4'd0, 1'b0, '0, '0, 8'd17, 32'sd1));
		add_item(mk_item(MODE_COMMIT, 4'd0, 1'b0, '0, '0, 8'd255, 32'sd1));
		add_item(mk_item(MODE_COMMIT, 4'd0, 1'b0, '0, '0, 8'd3, 32'sd2));
		// a write after commit but before the tick still reaches the pattern
		add_item(mk_item(MODE_WRITE, 4'd1, 1'b1, 32'd1, '0, 8'd0, 32'sd0));
		add_ticks(6);
		add_item(mk_item(MODE_BLINK, 4'd0, 1'b0, 32'd1, 32'd0, 8'd0, -32'sd1));
		add_item(mk_item(MODE_SOLID, 4'd0, 1'b1, '0, '0, 8'd0, 32'sd0));
		add_ticks(2);
		add_item(mk_item(MODE_SOLID, 4'd15, 1'b0, '1, '1, 8'd255, -32'sd1));
		add_item(mk_item(MODE_TICK, 4'd15, 1'b1, '1, '1, 8'd255, -32'sd1));
		add_item(mk_item(MODE_BLINK + 3'd1, 4'd0, 1'b0, '0, '0, 8'd0, 32'sd0));
		add_item(mk_item(MODE_SPARE_LAST, 4'd15, 1'b1, '1, '1, 8'd255, -32'sd1));
		add_item(mk_item(MODE_BLINK, 4'd0, 1'b0, '1, '1, 8'd0, 32'sh7fff_ffff));
		add_item(mk_item(MODE_TICK, 4'd0, 1'b0, '0, '0, 8'd0, 32'sd0));
		add_item(mk_item(MODE_BLINK, 4'd0, 1'b0, 32'd0, 32'd0, 8'd0, 32'sh8000_0000));
		add_ticks(2);
		add_item(mk_item(MODE_COMMIT, 4'd0, 1'b0, '0, '0, 8'd1, 32'sd0));
		add_ticks(2);

		// random part
		rand_count = 0;
		gen_drain = 1'b1;
		gen_hold = 1'b1;
		while (rand_count < RANDOM_ITEMS) begin
			if (gen_phase < 3 && rand_count >= (gen_phase + 1) * PHASE_ITEMS) begin
				gen_phase++;
				gen_drain = 1'b1;
				case (gen_phase)
				1: begin
					gen_tx = 74;
					gen_rx = 0;
				end
				2: begin
					gen_tx = 0;
					gen_rx = 74;
				end
				default: begin
					gen_tx = 6;
					gen_rx = 6;
					gen_hold = 1'b1;
				end
				endcase
			end
			kind = $urandom_range(99);
			if (kind < 50) begin
				n = ($urandom_range(7) == 0) ? $urandom_range(1, MAX_STEPS) : $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					add_item(mk_item(MODE_WRITE, k[3:0], 1'($urandom_range(1)), short_dur(),
						$urandom, 8'($urandom), $urandom));
				add_item(mk_item(MODE_COMMIT, 4'($urandom), 1'($urandom), $urandom, $urandom,
					n[7:0], pick_repeats()));
				if ($urandom_range(3) == 0)
					add_item(mk_item(MODE_WRITE, 4'($urandom_range(n - 1)),
						1'($urandom_range(1)), short_dur(), $urandom, 8'($urandom), $urandom));
				add_ticks($urandom_range(2, 16));
			end else if (kind < 65) begin
				add_item(mk_item(MODE_BLINK, 4'($urandom), 1'($urandom), short_dur(),
					short_dur(), 8'($urandom), pick_repeats()));
				add_ticks($urandom_range(2, 12));
			end else if (kind < 75) begin
				add_item(mk_item(MODE_SOLID, 4'($urandom), 1'($urandom), $urandom, $urandom,
					8'($urandom), $urandom));
				add_ticks($urandom_range(1, 4));
			end else begin
				add_item(mk_item(3'($urandom_range(MODE_SPARE_LAST)), 4'($urandom),
					1'($urandom), $urandom, $urandom, 8'($urandom), $urandom));
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		while (item_backlog.size() != 0 || push || in_flight != 0)
			@(negedge clk);
		repeat (END_DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (led_expected.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", led_expected.size()));
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/lps_pkg.sv
src/lps_front.sv
src/lps_cmd_fifo.sv
src/lps_back.sv
src/led_pattern_sequencer_core.sv
dv/testbench.sv
